>>> design/cfsu_pkg.sv
package cfsu_pkg;

    localparam int COORD_W          = 32;
    localparam int FEED_W           = 24;
    localparam int SEG_LEN_W        = 20;
    localparam int ANCHOR_W         = 64;
    localparam int CFG_IDX_W        = 3;
    localparam int SEG_CNT_W        = 7;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int SQ_W             = 2 * DIFF_W;
    localparam int ROOT_W           = SQ_W / 2;
    localparam int NUM_W            = ROOT_W + SEG_CNT_W;
    localparam int FNUM_W           = NUM_W + FEED_W;
    localparam int NUM_ANCHORS      = 4;
    localparam int NUM_AXES         = 3;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int COORD_WIDTH      = 32;

    localparam logic [SEG_LEN_W-1:0] SEG_LEN_RST = SEG_LEN_W'(1024);
    localparam logic [COORD_W-1:0]   LEN_MAX     = COORD_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic [FEED_W-1:0]    FEED_MAX    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_LEFT     = 3'd0,
        CFG_TOP_RIGHT    = 3'd1,
        CFG_BOTTOM_LEFT  = 3'd2,
        CFG_BOTTOM_RIGHT = 3'd3,
        CFG_SEG_LEN      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic [FEED_W-1:0]         feed_rate;
        logic                      rapid;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] cable_top_left;
        logic signed [COORD_W-1:0] cable_top_right;
        logic signed [COORD_W-1:0] cable_bottom_left;
        logic signed [COORD_W-1:0] cable_bottom_right;
        logic signed [COORD_W-1:0] segment_z;
        logic [FEED_W-1:0]         segment_feed;
        logic                      last_segment;
    } t_out_item;

    typedef struct packed {
        logic                                zero;
        logic                                rapid;
        logic [FEED_W-1:0]                   feed;
        logic [NUM_AXES-1:0][COORD_W-1:0]    tgt;
        logic [NUM_AXES-1:0]                 neg;
        logic [NUM_AXES-1:0][DIFF_W-1:0]     q;
        logic [NUM_AXES-1:0][SEG_CNT_W-1:0]  r;
        logic [SEG_CNT_W-1:0]                n;
        logic [ROOT_W-1:0]                   total;
    } t_cmd;

    typedef enum logic [3:0] {
        F_IDLE,
        F_SQ,
        F_XY_START,
        F_XY_WAIT,
        F_TOT_START,
        F_TOT_WAIT,
        F_N_START,
        F_N_WAIT,
        F_AX_START,
        F_AX_WAIT,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_STEP,
        B_END,
        B_LMUL,
        B_LROOT,
        B_LWAIT,
        B_MSQ,
        B_MROOT,
        B_MWAIT,
        B_NUM,
        B_FMUL,
        B_DIV,
        B_DWAIT,
        B_OUT
    } t_back_state;

    function automatic logic [DIFF_W-1:0] mag_of(input logic [DIFF_W-1:0] d);
        return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

    function automatic logic [SQ_W-1:0] sq_of(input logic [DIFF_W-1:0] m);
        return SQ_W'(m) * SQ_W'(m);
    endfunction

endpackage

>>> design/four_cable_move_segmenter_unit.sv
// Front end: a move is classified by two 33-step roots, then four 34-step divides;
// a zero-length move skips them and goes straight to the queue and out.
// Back end: each segment's pace is set by its shared root unit (four cable roots, plus
// a fifth for the feed unless rapid or zero feed) and its 64-step feed divider; up to 64 segments per move.
// Reset: config registers to their defaults, position and kept lengths to zero, queue empty.
module four_cable_move_segmenter_unit #(
    parameter int MAX_SEGMENTS = cfsu_pkg::MAX_SEGMENTS_DEF,
    parameter int QUEUE_DEPTH  = cfsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  cfsu_pkg::t_in_item                i_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output cfsu_pkg::t_out_item               o_item,
    input  logic                              i_cfg_we,
    input  logic [cfsu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cfsu_pkg::ANCHOR_W-1:0]     i_cfg_wdata
);
    import cfsu_pkg::*;

    logic [NUM_ANCHORS-1:0][ANCHOR_W-1:0] r_anchor;
    logic [SEG_LEN_W-1:0]                 r_seg_len;
    logic                                 w_recalc;

    logic                                 s_fq_valid;
    logic                                 s_fq_ready;
    t_cmd                                 s_fq_cmd;
    logic                                 s_qb_valid;
    logic                                 s_qb_ready;
    t_cmd                                 s_qb_cmd;

    always_comb begin
        w_recalc = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOP_LEFT, CFG_TOP_RIGHT, CFG_BOTTOM_LEFT, CFG_BOTTOM_RIGHT:
                    w_recalc = 1'b1;
                default: w_recalc = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor  <= '0;
            r_seg_len <= SEG_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOP_LEFT:     r_anchor[0] <= i_cfg_wdata;
                CFG_TOP_RIGHT:    r_anchor[1] <= i_cfg_wdata;
                CFG_BOTTOM_LEFT:  r_anchor[2] <= i_cfg_wdata;
                CFG_BOTTOM_RIGHT: r_anchor[3] <= i_cfg_wdata;
                CFG_SEG_LEN:      r_seg_len   <= i_cfg_wdata[SEG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    cfsu_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .i_seg_len   (r_seg_len),
        .o_cmd_valid (s_fq_valid),
        .i_cmd_ready (s_fq_ready),
        .o_cmd       (s_fq_cmd)
    );

    cfsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_fq_valid),
        .o_ready (s_fq_ready),
        .i_cmd   (s_fq_cmd),
        .o_valid (s_qb_valid),
        .i_ready (s_qb_ready),
        .o_cmd   (s_qb_cmd)
    );

    cfsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_qb_valid),
        .o_cmd_ready (s_qb_ready),
        .i_cmd       (s_qb_cmd),
        .i_anchor    (r_anchor),
        .i_recalc    (w_recalc),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

>>> design/cfsu_isqrt.sv
module cfsu_isqrt #(
    parameter int R_W = cfsu_pkg::SQ_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [R_W-1:0]     i_radicand,
    output logic               o_done,
    output logic [R_W/2-1:0]   o_root
);
    localparam int W     = R_W / 2;
    localparam int CNT_W = $clog2(W + 1);

    logic [R_W-1:0]   r_x;
    logic [W+2:0]     r_rem;
    logic [W-1:0]     r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W+2:0]     w_remp;
    logic [W+2:0]     w_trial;
    logic             w_ge;

    always_comb begin
        w_remp  = {r_rem[W:0], r_x[R_W-1 -: 2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = (w_remp >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[R_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_remp - w_trial) : w_remp;
            r_root <= {r_root[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> design/cfsu_divu.sv
module cfsu_divu #(
    parameter int N_W = 34,
    parameter int D_W = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quot,
    output logic [D_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W:0]     w_trial;
    logic [D_W:0]     w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_q[N_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(N_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

>>> design/cfsu_queue.sv
module cfsu_queue #(
    parameter int DEPTH = cfsu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cfsu_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output cfsu_pkg::t_cmd o_cmd
);
    import cfsu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> design/cfsu_front.sv
module cfsu_front #(
    parameter int MAX_SEGMENTS = cfsu_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  cfsu_pkg::t_in_item               i_item,
    input  logic [cfsu_pkg::SEG_LEN_W-1:0]   i_seg_len,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready,
    output cfsu_pkg::t_cmd                   o_cmd
);
    import cfsu_pkg::*;

    localparam int QN_W = DIFF_W + 1;

    t_front_state                    r_state;
    t_front_state                    n_state;
    logic [NUM_AXES-1:0][COORD_W-1:0] r_pos;
    logic [NUM_AXES-1:0][COORD_W-1:0] r_tgt;
    logic [NUM_AXES-1:0]             r_neg;
    logic [NUM_AXES-1:0][DIFF_W-1:0] r_mag;
    logic [NUM_AXES-1:0][DIFF_W-1:0] r_q;
    logic [NUM_AXES-1:0][SEG_CNT_W-1:0] r_r;
    logic [FEED_W-1:0]               r_feed;
    logic                            r_rapid;
    logic                            r_zero;
    logic [1:0]                      r_idx;
    logic [SQ_W-1:0]                 r_prod;
    logic [SQ_W-1:0]                 r_acc;
    logic [SQ_W-1:0]                 r_xysum;
    logic [ROOT_W-1:0]               r_xy;
    logic [ROOT_W-1:0]               r_total;
    logic [SEG_CNT_W-1:0]            r_n;

    logic [NUM_AXES-1:0][COORD_W-1:0] w_in_tgt;
    logic [NUM_AXES-1:0][DIFF_W-1:0]  w_d;
    logic [DIFF_W-1:0]               w_ax_mag;
    logic [SEG_LEN_W-1:0]            w_seg;

    logic                            s_sq_start;
    logic [SQ_W-1:0]                 s_sq_rad;
    logic                            s_sq_done;
    logic [ROOT_W-1:0]               s_sq_root;
    logic                            s_dv_start;
    logic [QN_W-1:0]                 s_dv_num;
    logic [SEG_LEN_W-1:0]            s_dv_den;
    logic                            s_dv_done;
    logic [QN_W-1:0]                 s_dv_quot;
    logic [SEG_LEN_W-1:0]            s_dv_rem;

    cfsu_isqrt #(.R_W(SQ_W)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_sq_start),
        .i_radicand (s_sq_rad),
        .o_done     (s_sq_done),
        .o_root     (s_sq_root)
    );

    cfsu_divu #(.N_W(QN_W), .D_W(SEG_LEN_W)) u_divu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_dv_start),
        .i_dividend (s_dv_num),
        .i_divisor  (s_dv_den),
        .o_done     (s_dv_done),
        .o_quot     (s_dv_quot),
        .o_rem      (s_dv_rem)
    );

    always_comb begin
        w_in_tgt[0] = i_item.target_x;
        w_in_tgt[1] = i_item.target_y;
        w_in_tgt[2] = i_item.target_z;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_d[a] = {w_in_tgt[a][COORD_W-1], w_in_tgt[a]} - {r_pos[a][COORD_W-1], r_pos[a]};
        end
        case (r_idx)
            2'd1:    w_ax_mag = r_mag[1];
            2'd2:    w_ax_mag = r_mag[2];
            default: w_ax_mag = r_mag[0];
        endcase
        w_seg = (i_seg_len == '0) ? SEG_LEN_W'(1) : i_seg_len;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = (w_d == '0) ? F_PUSH : F_SQ;
                end
            end
            F_SQ: begin
                if (r_idx == 2'd3) begin
                    n_state = F_XY_START;
                end
            end
            F_XY_START:  n_state = F_XY_WAIT;
            F_XY_WAIT:   n_state = s_sq_done ? F_TOT_START : F_XY_WAIT;
            F_TOT_START: n_state = F_TOT_WAIT;
            F_TOT_WAIT:  n_state = s_sq_done ? F_N_START : F_TOT_WAIT;
            F_N_START:   n_state = F_N_WAIT;
            F_N_WAIT:    n_state = s_dv_done ? F_AX_START : F_N_WAIT;
            F_AX_START:  n_state = F_AX_WAIT;
            F_AX_WAIT: begin
                if (s_dv_done) begin
                    n_state = (r_idx == 2'd2) ? F_PUSH : F_AX_START;
                end
            end
            F_PUSH: begin
                if (i_cmd_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == F_IDLE);
        o_cmd_valid = (r_state == F_PUSH);
        s_sq_start  = (r_state == F_XY_START) || (r_state == F_TOT_START);
        s_sq_rad    = (r_state == F_XY_START) ? r_xysum : r_acc;
        s_dv_start  = (r_state == F_N_START) || (r_state == F_AX_START);
        s_dv_num    = (r_state == F_N_START) ? QN_W'(r_xy) : QN_W'(w_ax_mag);
        s_dv_den    = (r_state == F_N_START) ? w_seg : SEG_LEN_W'(r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_pos   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_pos <= w_in_tgt;
                        r_idx <= '0;
                    end
                end
                F_SQ: begin
                    r_idx <= r_idx + 2'd1;
                end
                F_N_WAIT: begin
                    r_idx <= '0;
                end
                F_AX_WAIT: begin
                    if (s_dv_done) begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    r_tgt   <= w_in_tgt;
                    r_feed  <= i_item.feed_rate;
                    r_rapid <= i_item.rapid;
                    r_zero  <= (w_d == '0);
                    for (int a = 0; a < NUM_AXES; a++) begin
                        r_neg[a] <= w_d[a][DIFF_W-1];
                        r_mag[a] <= mag_of(w_d[a]);
                    end
                end
            end
            F_SQ: begin
                if (r_idx != 2'd3) begin
                    r_prod <= sq_of(w_ax_mag);
                end
                r_acc <= (r_idx == 2'd0) ? '0 : r_acc + r_prod;
                if (r_idx == 2'd3) begin
                    r_xysum <= r_acc;
                end
            end
            F_XY_WAIT: begin
                if (s_sq_done) begin
                    r_xy <= s_sq_root;
                end
            end
            F_TOT_WAIT: begin
                if (s_sq_done) begin
                    r_total <= s_sq_root;
                end
            end
            F_N_WAIT: begin
                if (s_dv_done) begin
                    if (s_dv_quot == '0) begin
                        r_n <= SEG_CNT_W'(1);
                    end else if (s_dv_quot > QN_W'(MAX_SEGMENTS)) begin
                        r_n <= SEG_CNT_W'(MAX_SEGMENTS);
                    end else begin
                        r_n <= s_dv_quot[SEG_CNT_W-1:0];
                    end
                end
            end
            F_AX_WAIT: begin
                if (s_dv_done) begin
                    case (r_idx)
                        2'd1: begin
                            r_q[1] <= s_dv_quot[DIFF_W-1:0];
                            r_r[1] <= s_dv_rem[SEG_CNT_W-1:0];
                        end
                        2'd2: begin
                            r_q[2] <= s_dv_quot[DIFF_W-1:0];
                            r_r[2] <= s_dv_rem[SEG_CNT_W-1:0];
                        end
                        default: begin
                            r_q[0] <= s_dv_quot[DIFF_W-1:0];
                            r_r[0] <= s_dv_rem[SEG_CNT_W-1:0];
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd.zero  = r_zero;
        o_cmd.rapid = r_rapid;
        o_cmd.feed  = r_feed;
        o_cmd.tgt   = r_tgt;
        o_cmd.neg   = r_neg;
        o_cmd.q     = r_q;
        o_cmd.r     = r_r;
        o_cmd.n     = r_n;
        o_cmd.total = r_total;
    end

endmodule

>>> design/cfsu_back.sv
module cfsu_back (
    input  logic                                                       i_clk,
    input  logic                                                       i_rst_n,
    input  logic                                                       i_cmd_valid,
    output logic                                                       o_cmd_ready,
    input  cfsu_pkg::t_cmd                                             i_cmd,
    input  logic [cfsu_pkg::NUM_ANCHORS-1:0][cfsu_pkg::ANCHOR_W-1:0]   i_anchor,
    input  logic                                                       i_recalc,
    output logic                                                       o_valid,
    input  logic                                                       i_ready,
    output cfsu_pkg::t_out_item                                        o_item
);
    import cfsu_pkg::*;

    t_back_state                          r_state;
    t_back_state                          n_state;
    t_cmd                                 r_cmd;
    logic                                 r_recalc_pend;
    logic                                 r_rc;
    logic                                 r_rc_phase;
    logic [NUM_AXES-1:0][COORD_W-1:0]     r_pos;
    logic [NUM_ANCHORS-1:0][COORD_W-1:0]  r_org;
    logic [NUM_ANCHORS:0][COORD_W-1:0]    r_last;
    logic [NUM_ANCHORS-1:0][COORD_W-1:0]  r_len;
    logic [SEG_CNT_W-1:0]                 r_k;
    logic [NUM_AXES-1:0][DIFF_W-1:0]      r_accq;
    logic [NUM_AXES-1:0][SEG_CNT_W-1:0]   r_accr;
    logic [NUM_AXES-1:0][SEG_CNT_W-1:0]   r_frac;
    logic [COORD_W-1:0]                   r_px;
    logic [COORD_W-1:0]                   r_py;
    logic [COORD_W-1:0]                   r_pz;
    logic [1:0]                           r_a;
    logic [SQ_W-1:0]                      r_sqa;
    logic [SQ_W-1:0]                      r_sqb;
    logic [2:0]                           r_mi;
    logic [SQ_W-1:0]                      r_mprod;
    logic [SQ_W-1:0]                      r_macc;
    logic [ROOT_W-1:0]                    r_mlen;
    logic [NUM_W-1:0]                     r_num;
    logic [FNUM_W-1:0]                    r_fnum;
    logic [FEED_W-1:0]                    r_feed;
    logic                                 r_out_valid;
    t_out_item                            r_out;

    logic [NUM_AXES-1:0][COORD_W-1:0]     w_end;
    logic [NUM_AXES-1:0][SEG_CNT_W:0]     w_rsum;
    logic [DIFF_W:0]                      w_emag;
    logic [DIFF_W:0]                      w_eoff;
    logic [DIFF_W:0]                      w_esum;
    logic [COORD_W-1:0]                   w_ax;
    logic [COORD_W-1:0]                   w_ay;
    logic [DIFF_W-1:0]                    w_dx;
    logic [DIFF_W-1:0]                    w_dy;
    logic [COORD_W-1:0]                   w_len_sat;
    logic [DIFF_W-1:0]                    w_mdiff;
    logic                                 w_last_seg;
    logic                                 w_out_free;
    t_out_item                            w_item;

    logic                                 s_sq_start;
    logic [SQ_W-1:0]                      s_sq_rad;
    logic                                 s_sq_done;
    logic [ROOT_W-1:0]                    s_sq_root;
    logic                                 s_dv_start;
    logic                                 s_dv_done;
    logic [FNUM_W-1:0]                    s_dv_quot;
    logic [ROOT_W:0]                      s_dv_rem;
    logic                                 s_out_load;

    cfsu_isqrt #(.R_W(SQ_W)) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_sq_start),
        .i_radicand (s_sq_rad),
        .o_done     (s_sq_done),
        .o_root     (s_sq_root)
    );

    cfsu_divu #(.N_W(FNUM_W), .D_W(ROOT_W + 1)) u_divu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_dv_start),
        .i_dividend (r_fnum),
        .i_divisor  ({1'b0, r_cmd.total}),
        .o_done     (s_dv_done),
        .o_quot     (s_dv_quot),
        .o_rem      (s_dv_rem)
    );

    always_comb begin
        w_emag = '0;
        w_eoff = '0;
        w_esum = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            w_rsum[a] = {1'b0, r_accr[a]} + {1'b0, r_cmd.r[a]};
            w_emag    = {1'b0, r_accq[a]} + (DIFF_W + 1)'(r_frac[a]);
            w_eoff    = r_cmd.neg[a] ? (~w_emag + (DIFF_W + 1)'(1)) : w_emag;
            w_esum    = {{2{r_pos[a][COORD_W-1]}}, r_pos[a]} + w_eoff;
            w_end[a]  = w_esum[COORD_W-1:0];
        end

        w_ax = i_anchor[r_a][COORD_W-1:0];
        w_ay = i_anchor[r_a][ANCHOR_W-1:COORD_W];
        w_dx = {w_ax[COORD_W-1], w_ax} - {r_px[COORD_W-1], r_px};
        w_dy = {w_ay[COORD_W-1], w_ay} - {r_py[COORD_W-1], r_py};
        w_len_sat = (s_sq_root > ROOT_W'(LEN_MAX)) ? LEN_MAX : s_sq_root[COORD_W-1:0];

        case (r_mi)
            3'd0, 3'd1, 3'd2, 3'd3:
                w_mdiff = {r_len[r_mi[1:0]][COORD_W-1], r_len[r_mi[1:0]]}
                        - {r_last[r_mi[1:0]][COORD_W-1], r_last[r_mi[1:0]]};
            default:
                w_mdiff = {r_pz[COORD_W-1], r_pz}
                        - {r_last[NUM_ANCHORS][COORD_W-1], r_last[NUM_ANCHORS]};
        endcase

        w_last_seg = (r_k == r_cmd.n);
        w_out_free = !r_out_valid || i_ready;

        if (r_cmd.zero) begin
            w_item.cable_top_left     = r_last[0] - r_org[0];
            w_item.cable_top_right    = r_last[1] - r_org[1];
            w_item.cable_bottom_left  = r_last[2] - r_org[2];
            w_item.cable_bottom_right = r_last[3] - r_org[3];
            w_item.segment_z          = r_pos[2];
            w_item.segment_feed       = r_cmd.feed;
            w_item.last_segment       = 1'b1;
        end else begin
            w_item.cable_top_left     = r_len[0] - r_org[0];
            w_item.cable_top_right    = r_len[1] - r_org[1];
            w_item.cable_bottom_left  = r_len[2] - r_org[2];
            w_item.cable_bottom_right = r_len[3] - r_org[3];
            w_item.segment_z          = r_pz;
            w_item.segment_feed       = r_feed;
            w_item.last_segment       = w_last_seg;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (r_recalc_pend) begin
                    n_state = B_LMUL;
                end else if (i_cmd_valid) begin
                    n_state = i_cmd.zero ? B_OUT : B_STEP;
                end
            end
            B_STEP:  n_state = B_END;
            B_END:   n_state = B_LMUL;
            B_LMUL:  n_state = B_LROOT;
            B_LROOT: n_state = B_LWAIT;
            B_LWAIT: begin
                if (s_sq_done) begin
                    if (r_a != 2'd3) begin
                        n_state = B_LMUL;
                    end else if (r_rc) begin
                        n_state = r_rc_phase ? B_IDLE : B_LMUL;
                    end else if (r_cmd.rapid || (r_cmd.feed == '0)) begin
                        n_state = B_OUT;
                    end else begin
                        n_state = B_MSQ;
                    end
                end
            end
            B_MSQ:   n_state = (r_mi == 3'd5) ? B_MROOT : B_MSQ;
            B_MROOT: n_state = B_MWAIT;
            B_MWAIT: n_state = s_sq_done ? B_NUM : B_MWAIT;
            B_NUM:   n_state = B_FMUL;
            B_FMUL:  n_state = B_DIV;
            B_DIV:   n_state = B_DWAIT;
            B_DWAIT: n_state = s_dv_done ? B_OUT : B_DWAIT;
            B_OUT: begin
                if (w_out_free) begin
                    n_state = (r_cmd.zero || w_last_seg) ? B_IDLE : B_STEP;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_ready = (r_state == B_IDLE) && !r_recalc_pend;
        s_sq_start  = (r_state == B_LROOT) || (r_state == B_MROOT);
        s_sq_rad    = (r_state == B_LROOT) ? (r_sqa + r_sqb) : r_macc;
        s_dv_start  = (r_state == B_DIV);
        s_out_load  = (r_state == B_OUT) && w_out_free;
        o_valid     = r_out_valid;
        o_item      = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_recalc_pend <= 1'b0;
            r_rc          <= 1'b0;
            r_rc_phase    <= 1'b0;
            r_pos         <= '0;
            r_org         <= '0;
            r_last        <= '0;
            r_out_valid   <= 1'b0;
            r_a           <= '0;
            r_mi          <= '0;
            r_k           <= '0;
        end else begin
            r_state <= n_state;
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end
            if (i_recalc) begin
                r_recalc_pend <= 1'b1;
            end
            case (r_state)
                B_IDLE: begin
                    r_a <= '0;
                    if (r_recalc_pend) begin
                        r_recalc_pend <= i_recalc;
                        r_rc          <= 1'b1;
                        r_rc_phase    <= 1'b0;
                    end else if (i_cmd_valid) begin
                        r_k <= '0;
                    end
                end
                B_STEP: begin
                    r_k <= r_k + SEG_CNT_W'(1);
                end
                B_END: begin
                    r_a <= '0;
                end
                B_LWAIT: begin
                    if (s_sq_done) begin
                        r_a <= r_a + 2'd1;
                        if (r_rc && !r_rc_phase) begin
                            r_org[r_a] <= w_len_sat;
                        end else if (r_rc) begin
                            r_last[r_a] <= w_len_sat;
                        end
                        if (r_a == 2'd3) begin
                            r_mi <= '0;
                            if (r_rc) begin
                                r_rc_phase <= 1'b1;
                                r_rc       <= !r_rc_phase;
                            end
                        end
                    end
                end
                B_MSQ: begin
                    r_mi <= r_mi + 3'd1;
                end
                B_OUT: begin
                    if (w_out_free && !r_cmd.zero) begin
                        for (int a = 0; a < NUM_ANCHORS; a++) begin
                            r_last[a] <= r_len[a];
                        end
                        r_last[NUM_ANCHORS] <= r_pz;
                        if (w_last_seg) begin
                            r_pos <= r_cmd.tgt;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out <= w_item;
        end
        case (r_state)
            B_IDLE: begin
                if (r_recalc_pend) begin
                    r_px <= '0;
                    r_py <= '0;
                end else if (i_cmd_valid) begin
                    r_cmd  <= i_cmd;
                    r_accq <= '0;
                    r_accr <= '0;
                    r_frac <= '0;
                end
            end
            B_STEP: begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_accq[a] <= r_accq[a] + r_cmd.q[a];
                    if (w_rsum[a] >= {1'b0, r_cmd.n}) begin
                        r_accr[a] <= SEG_CNT_W'(w_rsum[a] - {1'b0, r_cmd.n});
                        r_frac[a] <= r_frac[a] + SEG_CNT_W'(1);
                    end else begin
                        r_accr[a] <= w_rsum[a][SEG_CNT_W-1:0];
                    end
                end
            end
            B_END: begin
                r_px <= w_end[0];
                r_py <= w_end[1];
                r_pz <= w_end[2];
            end
            B_LMUL: begin
                r_sqa <= sq_of(mag_of(w_dx));
                r_sqb <= sq_of(mag_of(w_dy));
            end
            B_LWAIT: begin
                if (s_sq_done) begin
                    if (!r_rc) begin
                        r_len[r_a] <= w_len_sat;
                        if (r_cmd.feed == '0) begin
                            r_feed <= '0;
                        end else begin
                            r_feed <= r_cmd.feed;
                        end
                    end
                    if (r_rc && !r_rc_phase && (r_a == 2'd3)) begin
                        r_px <= r_pos[0];
                        r_py <= r_pos[1];
                    end
                end
            end
            B_MSQ: begin
                if (r_mi != 3'd5) begin
                    r_mprod <= sq_of(mag_of(w_mdiff));
                end
                r_macc <= (r_mi == 3'd0) ? '0 : r_macc + r_mprod;
            end
            B_MWAIT: begin
                if (s_sq_done) begin
                    r_mlen <= s_sq_root;
                end
            end
            B_NUM: begin
                r_num <= NUM_W'(r_mlen) * NUM_W'(r_cmd.n);
            end
            B_FMUL: begin
                r_fnum <= FNUM_W'(r_cmd.feed) * FNUM_W'(r_num);
            end
            B_DWAIT: begin
                if (s_dv_done) begin
                    r_feed <= (s_dv_quot[FNUM_W-1:FEED_W] != '0) ? FEED_MAX
                                                                  : s_dv_quot[FEED_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule
